// ----- rtl/core/ccc_pkg.sv -----
// Shared types, action codes and month-length helpers for the calendar clock counter.
package ccc_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam logic [YearW-1:0]   YearMax   = YearW'(9999);
  localparam logic [MonthW-1:0]  MonthMax  = MonthW'(12);
  localparam logic [HourW-1:0]   HourMax   = HourW'(23);
  localparam logic [HourW-1:0]   HourNoon  = HourW'(12);
  localparam logic [MinuteW-1:0] MinuteMax = MinuteW'(59);
  localparam logic [SecondW-1:0] SecondMax = SecondW'(59);

  // Divisibility by 25 through the multiplicative inverse mod 2^14.
  localparam logic [YearW-1:0] Inv25     = YearW'(7209);
  localparam logic [YearW-1:0] Div25Lim  = YearW'(655);

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_DATE = 2'd1,
    ACT_TIME = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [YearW-1:0]   new_year;
    logic [MonthW-1:0]  new_month;
    logic [DayW-1:0]    new_day;
    logic [HourW-1:0]   new_hour;
    logic [MinuteW-1:0] new_minute;
    logic [SecondW-1:0] new_second;
  } in_t;

  typedef struct packed {
    logic [YearW-1:0]   cur_year;
    logic [MonthW-1:0]  cur_month;
    logic [DayW-1:0]    cur_day;
    logic [HourW-1:0]   shown_hour;
    logic [MinuteW-1:0] cur_minute;
    logic [SecondW-1:0] cur_second;
    logic               is_pm;
  } out_t;

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian leap test: divisible by 4 and not by 100, or divisible by 400.
  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    logic               div25;
    logic               div4;
    logic               div16;
    prod  = {{YearW{1'b0}}, y} * {{YearW{1'b0}}, Inv25};
    div25 = (prod[YearW-1:0] <= Div25Lim);
    div4  = (y[1:0] == 2'b00);
    div16 = (y[3:0] == 4'b0000);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  // Days in month m (1-12); anything else counts as 31.
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic              leap);
    logic [DayW-1:0] len;
    if (m < MonthW'(1) || m > MonthMax) begin
      len = DayW'(31);
    end else if (m == MonthW'(2) && leap) begin
      len = DayW'(29);
    end else begin
      len = MonthLen[m - MonthW'(1)];
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/calendar_clock_counter_core.sv -----
// Calendar clock counter core: tick, date load and time load with one result per transfer.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one action per
//   transfer: a one-second tick, a date load or a time load. Action code three
//   changes nothing. Out-of-range load values saturate to the nearest legal one.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns the date and
//   time after each input transfer, exactly one result per input.
//   Configuration: cfg_we_i writes cfg_wdata_i into the 12/24-hour mode bit;
//   write it only while no transfer is in flight.
// Pipeline and throughput:
//   A transfer passes the input register, then the calendar update into the
//   result register. One transfer per cycle sustained while out_stall_i is low,
//   since the whole second..year carry settles combinationally.
// Reset:
//   Clock restarts at 2025-04-30 12:00:00 in 24-hour mode; both stages empty.
// Back-pressure:
//   With out_stall_i high the result register holds; the input register still
//   takes one more transfer, then in_stall_o rises until the result drains.
module calendar_clock_counter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ccc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ccc_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import ccc_pkg::*;

  // Pipeline control
  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  logic adv;     // result register free to take a new value
  logic fire;    // input register moves into the result register

  logic hour_mode_q;

  // Calendar state
  logic [YearW-1:0]   year_q,   year_d;
  logic [MonthW-1:0]  month_q,  month_d;
  logic [DayW-1:0]    day_q,    day_d;
  logic [HourW-1:0]   hour_q,   hour_d;
  logic [MinuteW-1:0] minute_q, minute_d;
  logic [SecondW-1:0] second_q, second_d;

  // Load clamping and month length
  logic [YearW-1:0]  ld_year;
  logic [MonthW-1:0] ld_month;
  logic [DayW-1:0]   ld_day;
  logic [YearW-1:0]  leap_year_sel;
  logic [MonthW-1:0] len_month_sel;
  logic [DayW-1:0]   mlen;
  logic              is_date;
  logic              at_end;
  logic [HourW-1:0]  shown_hour;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Input register: accept whenever it is empty or draining this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      hour_mode_q <= cfg_wdata_i;
    end
  end

  // Saturate the date load fields
  always_comb begin
    ld_year  = (in_q.new_year > YearMax) ? YearMax : in_q.new_year;
    ld_month = in_q.new_month;
    if (ld_month < MonthW'(1)) begin
      ld_month = MonthW'(1);
    end else if (ld_month > MonthMax) begin
      ld_month = MonthMax;
    end
  end

  // One leap test serves both the date load and the day rollover
  assign is_date       = (in_q.action == ACT_DATE);
  assign leap_year_sel = is_date ? ld_year : year_q;
  assign len_month_sel = is_date ? ld_month : month_q;
  assign mlen          = month_length(len_month_sel, leap_year(leap_year_sel));

  always_comb begin
    ld_day = in_q.new_day;
    if (ld_day < DayW'(1)) begin
      ld_day = DayW'(1);
    end else if (ld_day > mlen) begin
      ld_day = mlen;
    end
  end

  assign at_end = (year_q >= YearMax) && (month_q == MonthMax) && (day_q == DayW'(31)) &&
                  (hour_q == HourMax) && (minute_q == MinuteMax) &&
                  (second_q == SecondMax);

  // Next calendar state
  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    unique case (in_q.action)
      ACT_TICK: begin
        if (!at_end) begin
          // Advance seconds and ripple the carry upward
          if (second_q < SecondMax) begin
            second_d = second_q + SecondW'(1);
          end else begin
            second_d = '0;
            if (minute_q < MinuteMax) begin
              minute_d = minute_q + MinuteW'(1);
            end else begin
              minute_d = '0;
              if (hour_q < HourMax) begin
                hour_d = hour_q + HourW'(1);
              end else begin
                hour_d = '0;
                if (day_q < mlen) begin
                  day_d = day_q + DayW'(1);
                end else begin
                  day_d = DayW'(1);
                  if (month_q < MonthMax) begin
                    month_d = month_q + MonthW'(1);
                  end else begin
                    month_d = MonthW'(1);
                    if (year_q < YearMax) begin
                      year_d = year_q + YearW'(1);
                    end
                  end
                end
              end
            end
          end
        end
      end
      ACT_DATE: begin
        year_d  = ld_year;
        month_d = ld_month;
        day_d   = ld_day;
      end
      ACT_TIME: begin
        hour_d   = (in_q.new_hour > HourMax) ? HourMax : in_q.new_hour;
        minute_d = (in_q.new_minute > MinuteMax) ? MinuteMax : in_q.new_minute;
        second_d = (in_q.new_second > SecondMax) ? SecondMax : in_q.new_second;
      end
      default: begin
        // Unused action: hold everything
      end
    endcase
  end

  // Hour as shown: 0-23, or 1-12 with the PM flag
  always_comb begin
    if (hour_mode_q) begin
      shown_hour = hour_d;
    end else if (hour_d >= HourNoon) begin
      shown_hour = hour_d - HourNoon;
    end else begin
      shown_hour = hour_d;
    end
    if (!hour_mode_q && shown_hour == '0) begin
      shown_hour = HourNoon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= YearW'(2025);
      month_q  <= MonthW'(4);
      day_q    <= DayW'(30);
      hour_q   <= HourW'(12);
      minute_q <= '0;
      second_q <= '0;
    end else if (fire) begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.cur_year   <= year_d;
      out_q.cur_month  <= month_d;
      out_q.cur_day    <= day_d;
      out_q.shown_hour <= shown_hour;
      out_q.cur_minute <= minute_d;
      out_q.cur_second <= second_d;
      out_q.is_pm      <= (hour_d >= HourNoon);
    end
  end

  // Assertions
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= MonthW'(1)) && (month_q <= MonthMax) && (day_q >= DayW'(1)) &&
    (day_q <= month_length(month_q, leap_year(year_q))) && (year_q <= YearMax))
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HourMax) && (minute_q <= MinuteMax) && (second_q <= SecondMax))
    else $error("clock time out of range");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("transfer into result register lost");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(second_q) && $stable(day_q) && $stable(year_q))
    else $error("calendar state moved without a transfer");

endmodule
